### sv/baid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baid_pkg
// Shared types, sizes and register codes of the box-average image downscaler.
// ----------------------------------------------------------------------------
package baid_pkg;

   localparam int DIM_W     = 13;   // image dimension registers
   localparam int PIX_W     = 8;    // one color channel
   localparam int LANE_W    = 16;   // one channel sum
   localparam int NUM_LANES = 4;    // red, green, blue, alpha
   localparam int CSR_IDX_W = 3;

   localparam int DEF_MAX_OUT_WIDTH = 4096;
   localparam int DEF_MAX_KERNEL    = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;

   typedef logic [NUM_LANES-1:0][LANE_W-1:0] lane_sum_type;
   typedef logic [NUM_LANES-1:0][PIX_W-1:0]  lane_pix_type;

   typedef struct packed {
      logic         err;
      logic         last;
      lane_sum_type sum;
   } mean_req_type;

   typedef struct packed {
      logic         err;
      logic         last;
      lane_pix_type mean;
   } mean_rsp_type;

   function automatic lane_sum_type lane_add(lane_sum_type a, lane_sum_type b);
      lane_sum_type r;
      for (int k = 0; k < NUM_LANES; k++) begin
         r[k] = a[k] + b[k];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/box_average_image_downscaler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_average_image_downscaler_core
// Box-filter downscaler for raster-order RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock once configured, unless the mean divider
// stalls. After reset and after every write to a size register, input is
// held off while two iterative dividers (one quotient bit per clock over 13
// bits) work out the kernel width and height, plus start and settle cycles.
// Horizontal block sums are merged with the per-column line store (one
// synchronous RAM, read on pixel acceptance, written when the registered
// entry moves on, with write forwarding). Each finished block is divided by
// its pixel count in an 8-stage pipeline.
// An invalid size setting answers every pixel with a config_error result.
// The line store needs no clearing pass: the first block row overwrites it.
// ----------------------------------------------------------------------------
module box_average_image_downscaler_core
   import baid_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_KERNEL    = DEF_MAX_KERNEL
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_data,
   // source pixels
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [PIX_W-1:0]     req_pix_red,
   input  wire logic [PIX_W-1:0]     req_pix_green,
   input  wire logic [PIX_W-1:0]     req_pix_blue,
   input  wire logic [PIX_W-1:0]     req_pix_alpha,
   // output pixels
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [PIX_W-1:0]          rsp_out_red,
   output logic [PIX_W-1:0]          rsp_out_green,
   output logic [PIX_W-1:0]          rsp_out_blue,
   output logic [PIX_W-1:0]          rsp_out_alpha,
   output logic                      rsp_frame_last,
   output logic                      rsp_config_error
);

   localparam int KW    = $clog2(MAX_KERNEL + 1);
   localparam int CNT_W = 2 * KW;
   localparam int AW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

   // ---------------- configuration ----------------
   logic [DIM_W-1:0] src_w_ff, src_h_ff, out_w_ff, out_h_ff;
   logic             cfg_hit;
   logic             start_ff, settle_ff;
   logic             dw_busy, dh_busy;
   logic [DIM_W-1:0] dw_q, dh_q;
   logic             cfg_busy;
   logic [KW-1:0]    kw_ff, kh_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             err_ff;

   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid && csr_ready && (csr_index <= REG_OUT_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_W'(1);
         src_h_ff <= DIM_W'(1);
         out_w_ff <= DIM_W'(1);
         out_h_ff <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SRC_WIDTH:  src_w_ff <= csr_data;
            REG_SRC_HEIGHT: src_h_ff <= csr_data;
            REG_OUT_WIDTH:  out_w_ff <= csr_data;
            REG_OUT_HEIGHT: out_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 1'b1;
         settle_ff <= 1'b0;
      end else begin
         start_ff  <= cfg_hit;
         settle_ff <= dw_busy || dh_busy;
      end
   end

   baid_dim_div #(.W(DIM_W)) u_kw_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (src_w_ff),
      .divisor  (out_w_ff),
      .busy     (dw_busy),
      .quotient (dw_q)
   );

   baid_dim_div #(.W(DIM_W)) u_kh_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (src_h_ff),
      .divisor  (out_h_ff),
      .busy     (dh_busy),
      .quotient (dh_q)
   );

   assign cfg_busy = start_ff || dw_busy || dh_busy || settle_ff;

   // follows the dividers; only used once they are idle
   always_ff @(posedge clock) begin
      kw_ff  <= dw_q[KW-1:0];
      kh_ff  <= dh_q[KW-1:0];
      cnt_ff <= CNT_W'(dw_q[KW-1:0]) * CNT_W'(dh_q[KW-1:0]);
      err_ff <= (out_w_ff == '0) || (out_h_ff == '0) ||
                (32'(out_w_ff) > 32'(MAX_OUT_WIDTH)) ||
                (dw_q == '0) || (dh_q == '0) ||
                (32'(dw_q) > 32'(MAX_KERNEL)) || (32'(dh_q) > 32'(MAX_KERNEL));
   end

   // ---------------- frame counters ----------------
   logic [DIM_W-1:0] src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [DIM_W-1:0] src_col_in, src_row_in, out_col_in, out_row_in;
   logic [KW-1:0]    kernel_col_ff, kernel_row_ff, kernel_col_in, kernel_row_in;
   lane_sum_type     run_ff, run_in;

   lane_sum_type     pix;
   lane_sum_type     run_sum;
   logic [KW-1:0]    kc_inc;
   logic             active;
   logic             col_done;
   logic             req_fire;
   logic             s1_ld;
   logic             div_ready;

   assign req_ready = s1_ld && !cfg_busy;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      pix[0]   = LANE_W'(req_pix_red);
      pix[1]   = LANE_W'(req_pix_green);
      pix[2]   = LANE_W'(req_pix_blue);
      pix[3]   = LANE_W'(req_pix_alpha);
      run_sum  = lane_add(run_ff, pix);
      kc_inc   = kernel_col_ff + KW'(1);
      active   = (out_col_ff < out_w_ff) && (out_row_ff < out_h_ff);
      col_done = active && (kc_inc == kw_ff);

      src_col_in    = src_col_ff + DIM_W'(1);
      src_row_in    = src_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      kernel_col_in = kernel_col_ff;
      kernel_row_in = kernel_row_ff;
      run_in        = run_ff;

      if (active) begin
         if (col_done) begin
            kernel_col_in = '0;
            run_in        = '0;
            out_col_in    = out_col_ff + DIM_W'(1);
         end else begin
            kernel_col_in = kc_inc;
            run_in        = run_sum;
         end
      end

      // end of a source row
      if (src_col_in >= src_w_ff) begin
         src_col_in    = '0;
         out_col_in    = '0;
         kernel_col_in = '0;
         run_in        = '0;
         kernel_row_in = kernel_row_ff + KW'(1);
         if (kernel_row_in >= kh_ff) begin
            kernel_row_in = '0;
            if (out_row_ff < out_h_ff) begin
               out_row_in = out_row_ff + DIM_W'(1);
            end
         end
         src_row_in = src_row_ff + DIM_W'(1);
         // end of frame
         if (src_row_in >= src_h_ff) begin
            src_row_in    = '0;
            out_row_in    = '0;
            kernel_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         kernel_col_ff <= '0;
         kernel_row_ff <= '0;
         run_ff        <= '0;
      end else if (req_fire && !err_ff) begin
         src_col_ff    <= src_col_in;
         src_row_ff    <= src_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         kernel_col_ff <= kernel_col_in;
         kernel_row_ff <= kernel_row_in;
         run_ff        <= run_in;
      end
   end

   // ---------------- line store read-modify-write ----------------
   lane_sum_type     col_sum_mem [MAX_OUT_WIDTH];
   lane_sum_type     rd_ff;
   logic             s1_v_ff, s1_err_ff, s1_first_ff, s1_emit_ff, s1_last_ff;
   logic [AW-1:0]    s1_idx_ff;
   lane_sum_type     s1_run_ff;
   logic             wr_v_ff;
   logic [AW-1:0]    wr_idx_ff;
   lane_sum_type     wr_data_ff;
   lane_sum_type     mem_cur;
   lane_sum_type     acc;
   logic             wr_en;
   mean_req_type     div_req;
   logic             div_valid;

   assign s1_ld = !s1_v_ff || div_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ld) begin
         s1_v_ff <= req_fire && (err_ff || col_done);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ld) begin
         s1_err_ff   <= err_ff;
         s1_first_ff <= kernel_row_ff == '0;
         s1_emit_ff  <= kernel_row_ff == (kh_ff - KW'(1));
         s1_last_ff  <= (out_row_ff == (out_h_ff - DIM_W'(1))) &&
                        (out_col_ff == (out_w_ff - DIM_W'(1)));
         s1_idx_ff   <= AW'(out_col_ff);
         s1_run_ff   <= run_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= col_sum_mem[AW'(out_col_ff)];
      end
      if (wr_en) begin
         col_sum_mem[s1_idx_ff] <= acc;
      end
   end

   // last write may have landed on the same edge as this entry's read
   always_comb begin
      mem_cur = (wr_v_ff && (wr_idx_ff == s1_idx_ff)) ? wr_data_ff : rd_ff;
      acc     = s1_first_ff ? s1_run_ff : lane_add(mem_cur, s1_run_ff);
      wr_en   = s1_v_ff && !s1_err_ff && div_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_v_ff <= 1'b0;
      end else if (wr_en) begin
         wr_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_idx_ff  <= s1_idx_ff;
         wr_data_ff <= acc;
      end
   end

   // ---------------- mean division ----------------
   mean_rsp_type div_rsp;

   always_comb begin
      div_valid    = s1_v_ff && (s1_err_ff || s1_emit_ff);
      div_req.err  = s1_err_ff;
      div_req.last = !s1_err_ff && s1_last_ff;
      div_req.sum  = s1_err_ff ? '0 : acc;
   end

   baid_mean_div #(.CNT_W(CNT_W)) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_req),
      .cnt       (cnt_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (div_rsp)
   );

   // a zero pixel count under a bad setting would divide to all ones
   assign rsp_out_red      = div_rsp.err ? '0 : div_rsp.mean[0];
   assign rsp_out_green    = div_rsp.err ? '0 : div_rsp.mean[1];
   assign rsp_out_blue     = div_rsp.err ? '0 : div_rsp.mean[2];
   assign rsp_out_alpha    = div_rsp.err ? '0 : div_rsp.mean[3];
   assign rsp_frame_last   = div_rsp.last;
   assign rsp_config_error = div_rsp.err;

`ifndef SYNTHESIS
   a_cfg_holds_input: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> !req_ready)
      else $error("pixel input open right after a size register write");

   a_kcol_range: assert property (@(posedge clock) disable iff (reset)
      (!cfg_busy && !err_ff) |-> (kernel_col_ff < kw_ff))
      else $error("kernel column counter out of range");

   a_krow_range: assert property (@(posedge clock) disable iff (reset)
      (!cfg_busy && !err_ff) |-> (kernel_row_ff < kh_ff))
      else $error("kernel row counter out of range");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_config_error) |->
         (rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '0) &&
         (rsp_out_alpha == '0) && !rsp_frame_last)
      else $error("config error result carries a nonzero payload");

   a_err_to_stage: assert property (@(posedge clock) disable iff (reset)
      (req_fire && err_ff) |=> (s1_v_ff && s1_err_ff))
      else $error("pixel under invalid configuration did not produce an error result");
`endif

endmodule
`default_nettype wire

### sv/baid_dim_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baid_dim_div
// Iterative restoring divider, one quotient bit per clock, for kernel sizes.
// ----------------------------------------------------------------------------
module baid_dim_div
   import baid_pkg::*;
#(
   parameter int W = DIM_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic [W-1:0]      quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     dvs_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [W:0] trial;
   logic [W:0] diff;
   logic       fits;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= fits ? W'(diff) : W'(trial);
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### sv/baid_mean_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baid_mean_div
// Pipelined restoring divider: four channel sums over the kernel pixel count,
// one quotient bit per stage, with per-stage flow control.
// ----------------------------------------------------------------------------
module baid_mean_div
   import baid_pkg::*;
#(
   parameter int CNT_W = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire mean_req_type     in_data,
   input  wire logic [CNT_W-1:0] cnt,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output mean_rsp_type          out_data
);

   localparam int STAGES = PIX_W;
   localparam int REM_W  = LANE_W + 1;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] ld;
   lane_sum_type      rem_ff   [STAGES];
   lane_pix_type      quo_ff   [STAGES];
   logic              err_ff   [STAGES];
   logic              last_ff  [STAGES];

   lane_sum_type      src_rem  [STAGES];
   lane_pix_type      src_quo  [STAGES];
   logic              src_vld  [STAGES];
   logic              src_err  [STAGES];
   logic              src_last [STAGES];
   lane_sum_type      rem_in   [STAGES];
   lane_pix_type      quo_in   [STAGES];

   // a stage may load when it is empty or its content moves on
   always_comb begin
      ld[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         ld[s] = !vld_ff[s] || ld[s+1];
      end
   end

   always_comb begin
      src_rem[0]  = in_data.sum;
      src_quo[0]  = '0;
      src_vld[0]  = in_valid;
      src_err[0]  = in_data.err;
      src_last[0] = in_data.last;
      for (int s = 1; s < STAGES; s++) begin
         src_rem[s]  = rem_ff[s-1];
         src_quo[s]  = quo_ff[s-1];
         src_vld[s]  = vld_ff[s-1];
         src_err[s]  = err_ff[s-1];
         src_last[s] = last_ff[s-1];
      end
   end

   // stage s decides quotient bit STAGES-1-s
   always_comb begin
      logic [REM_W-1:0] dvs;
      logic [REM_W-1:0] num;
      for (int s = 0; s < STAGES; s++) begin
         dvs = REM_W'(cnt) << (STAGES - 1 - s);
         for (int k = 0; k < NUM_LANES; k++) begin
            num = {1'b0, src_rem[s][k]};
            if (num >= dvs) begin
               rem_in[s][k] = LANE_W'(num - dvs);
               quo_in[s][k] = src_quo[s][k] | (PIX_W'(1) << (STAGES - 1 - s));
            end else begin
               rem_in[s][k] = src_rem[s][k];
               quo_in[s][k] = src_quo[s][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (ld[s]) begin
               vld_ff[s] <= src_vld[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (ld[s]) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            err_ff[s]  <= src_err[s];
            last_ff[s] <= src_last[s];
         end
      end
   end

   assign in_ready      = ld[0];
   assign out_valid     = vld_ff[STAGES-1];
   assign out_data.err  = err_ff[STAGES-1];
   assign out_data.last = last_ff[STAGES-1];
   assign out_data.mean = quo_ff[STAGES-1];

endmodule
`default_nettype wire

### test/box_average_image_downscaler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_image_downscaler_core_tb
// Self-checking bench for the box-average image downscaler.
// ----------------------------------------------------------------------------
// A short directed table covers reset defaults, each invalid size setting
// but a zero kernel height, and small kernels with ignored edge columns.
// Then random frames follow: random sizes and kernels, the largest kernel
// and the widest output, and bad settings now and then. A behavioral
// downscaler in the bench predicts every output pixel. A scoreboard checks
// each output transaction in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module box_average_image_downscaler_core_tb;
   import baid_pkg::*;

   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 32;     // covers the divider pipeline
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;   // no such register

   typedef enum logic {ROW_REG, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [DIM_W-1:0]      data;
      lane_pix_type          pix;
      bit                    typed;
      mean_rsp_type          want;
   } stim_row_type;

   localparam mean_rsp_type ERR_PIXEL = '{err: 1'b1, last: 1'b0, mean: '0};

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [DIM_W-1:0]     csr_data      = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pix_red   = '0;
   logic [PIX_W-1:0]     req_pix_green = '0;
   logic [PIX_W-1:0]     req_pix_blue  = '0;
   logic [PIX_W-1:0]     req_pix_alpha = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [PIX_W-1:0]     rsp_out_red;
   logic [PIX_W-1:0]     rsp_out_green;
   logic [PIX_W-1:0]     rsp_out_blue;
   logic [PIX_W-1:0]     rsp_out_alpha;
   logic                 rsp_frame_last;
   logic                 rsp_config_error;

   box_average_image_downscaler_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pix_red      (req_pix_red),
      .req_pix_green    (req_pix_green),
      .req_pix_blue     (req_pix_blue),
      .req_pix_alpha    (req_pix_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_config_error (rsp_config_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[box_average_image_downscaler_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Behavioral downscaler
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0] cfg_src_w, cfg_src_h, cfg_out_w, cfg_out_h;
   logic [DIM_W-1:0] src_col, src_row, out_col, out_row;
   logic [4:0]       kern_col, kern_row;
   lane_sum_type     run_sum;
   lane_sum_type     line_sum [DEF_MAX_OUT_WIDTH];

   mean_rsp_type     pending_pixels [$];
   int               mismatch_count = 0;
   int               tx_burst = 0;
   int               rx_burst = 0;

   function automatic void restart_frame_state();
      src_col  = '0;
      src_row  = '0;
      out_col  = '0;
      out_row  = '0;
      kern_col = '0;
      kern_row = '0;
      run_sum  = '0;
   endfunction

   // Returns 1 when the pixel finishes a block (or the setting is invalid).
   function automatic bit predict_downscale(input lane_pix_type pix,
                                            output mean_rsp_type res);
      int unsigned kw, kh, cnt;
      lane_sum_type acc;
      bit hit;
      res = '0;
      hit = 1'b0;
      if (cfg_out_w == 0 || cfg_out_h == 0 || cfg_out_w > DEF_MAX_OUT_WIDTH) begin
         kw = 0;
         kh = 0;
      end else begin
         kw = cfg_src_w / cfg_out_w;
         kh = cfg_src_h / cfg_out_h;
      end
      if (kw == 0 || kh == 0 || kw > DEF_MAX_KERNEL || kh > DEF_MAX_KERNEL) begin
         res.err = 1'b1;
         return 1'b1;
      end
      if (out_col < cfg_out_w && out_row < cfg_out_h) begin
         for (int k = 0; k < NUM_LANES; k++) begin
            run_sum[k] = run_sum[k] + pix[k];
         end
         kern_col++;
         if (kern_col == kw) begin
            for (int k = 0; k < NUM_LANES; k++) begin
               acc[k] = (kern_row == 0) ? run_sum[k] : line_sum[out_col][k] + run_sum[k];
            end
            line_sum[out_col] = acc;
            kern_col = '0;
            run_sum  = '0;
            if (kern_row == kh - 1) begin
               cnt = kw * kh;
               for (int k = 0; k < NUM_LANES; k++) begin
                  res.mean[k] = PIX_W'(acc[k] / cnt);
               end
               res.last = (out_row == cfg_out_h - 1) && (out_col == cfg_out_w - 1);
               hit = 1'b1;
            end
            out_col++;
         end
      end
      src_col++;
      if (src_col >= cfg_src_w) begin
         src_col  = '0;
         out_col  = '0;
         kern_col = '0;
         run_sum  = '0;
         kern_row++;
         if (kern_row >= kh) begin
            kern_row = '0;
            if (out_row < cfg_out_h) out_row++;
         end
         src_row++;
         if (src_row >= cfg_src_h) restart_frame_state();
      end
      return hit;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int draw_gap(ref int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic lane_pix_type rgba(int r, int g, int b, int a);
      return {PIX_W'(a), PIX_W'(b), PIX_W'(g), PIX_W'(r)};
   endfunction

   function automatic lane_pix_type random_pixel();
      return rgba($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   task automatic send_pixel(input lane_pix_type pix, input bit typed,
                             input mean_rsp_type want);
      int gap;
      bit hit;
      mean_rsp_type res;
      gap = draw_gap(tx_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pix_red   <= pix[0];
      req_pix_green <= pix[1];
      req_pix_blue  <= pix[2];
      req_pix_alpha <= pix[3];
      do @(posedge clock); while (!req_ready);
      hit = predict_downscale(pix, res);
      if (typed) pending_pixels.push_back(want);
      else if (hit) pending_pixels.push_back(res);
   endtask

   // Always waits for a clock edge, so req_valid is never driven twice in a step.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // Register writes only once the block has gone quiet.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  cfg_src_w = val;
         REG_SRC_HEIGHT: cfg_src_h = val;
         REG_OUT_WIDTH:  cfg_out_w = val;
         REG_OUT_HEIGHT: cfg_out_h = val;
         default: ;
      endcase
      if (idx <= REG_OUT_HEIGHT) restart_frame_state();
   endtask

   stim_row_type directed_rows [$];

   task automatic add_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      stim_row_type row;
      row = '{kind: ROW_REG, idx: idx, data: DIM_W'(val), pix: '0, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_pix(input lane_pix_type pix, input bit typed, input mean_rsp_type want);
      stim_row_type row;
      row = '{kind: ROW_PIX, idx: '0, data: '0, pix: pix, typed: typed, want: want};
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Output side: random stalls and scoreboard
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      forever begin
         gap = draw_gap(rx_burst);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      mean_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("output pixel transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("out_red",      want.mean[0], rsp_out_red);
            check_field("out_green",    want.mean[1], rsp_out_green);
            check_field("out_blue",     want.mean[2], rsp_out_blue);
            check_field("out_alpha",    want.mean[3], rsp_out_alpha);
            check_field("frame_last",   want.last,    rsp_frame_last);
            check_field("config_error", want.err,     rsp_config_error);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int sent, n, kw, kh, phase;
      int sw, sh, ow, oh;
      lane_pix_type p;

      cfg_src_w = 1;
      cfg_src_h = 1;
      cfg_out_w = 1;
      cfg_out_h = 1;
      restart_frame_state();

      // 1x1 defaults pass each pixel through as a whole frame
      p = rgba(255, 0, 255, 0);
      add_pix(p, 1'b1, '{err: 1'b0, last: 1'b1, mean: p});
      p = rgba(0, 255, 0, 255);
      add_pix(p, 1'b1, '{err: 1'b0, last: 1'b1, mean: p});
      add_reg(REG_SPARE, 8191);                  // unknown index, no restart
      p = rgba(128, 127, 1, 254);
      add_pix(p, 1'b1, '{err: 1'b0, last: 1'b1, mean: p});
      // invalid settings
      add_reg(REG_OUT_WIDTH, 0);
      add_pix(rgba(1, 2, 3, 4), 1'b1, ERR_PIXEL);
      add_reg(REG_OUT_WIDTH, 8191);              // wider than the line store
      add_pix(rgba(255, 255, 255, 255), 1'b1, ERR_PIXEL);
      add_reg(REG_OUT_WIDTH, 1);
      add_reg(REG_SRC_WIDTH, 17);                // kernel too wide
      add_pix(rgba(9, 8, 7, 6), 1'b1, ERR_PIXEL);
      add_reg(REG_SRC_WIDTH, 1);
      add_reg(REG_OUT_WIDTH, 2);                 // kernel width zero
      add_pix(rgba(0, 0, 0, 0), 1'b1, ERR_PIXEL);
      add_reg(REG_OUT_WIDTH, 1);
      add_reg(REG_OUT_HEIGHT, 0);
      add_pix(rgba(17, 34, 51, 68), 1'b1, ERR_PIXEL);
      add_reg(REG_OUT_HEIGHT, 1);
      add_reg(REG_SRC_HEIGHT, 17);               // kernel too tall
      add_pix(rgba(200, 100, 50, 25), 1'b1, ERR_PIXEL);
      // 3x2 kernel, one output
      add_reg(REG_SRC_HEIGHT, 2);
      add_reg(REG_SRC_WIDTH, 3);
      add_pix(rgba(255, 255, 255, 255), 1'b0, '0);
      add_pix(rgba(255, 0, 255, 0), 1'b0, '0);
      add_pix(rgba(0, 0, 0, 0), 1'b0, '0);
      add_pix(rgba(255, 255, 0, 0), 1'b0, '0);
      add_pix(rgba(1, 254, 128, 127), 1'b0, '0);
      add_pix(rgba(255, 255, 255, 255), 1'b0, '0);
      // 3 columns onto 2 outputs: last column ignored
      add_reg(REG_SRC_HEIGHT, 1);
      add_reg(REG_OUT_WIDTH, 2);
      add_pix(rgba(10, 20, 30, 40), 1'b0, '0);
      add_pix(rgba(50, 60, 70, 80), 1'b0, '0);
      add_pix(rgba(90, 100, 110, 120), 1'b0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            write_reg(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin              // largest kernel, one full frame
               sw = 16; sh = 16; ow = 1; oh = 1; n = 260;
            end
            1: begin              // widest output, every pixel is a block
               sw = 4096; sh = 1; ow = 4096; oh = 1; n = 150;
            end
            2: begin              // all-ones width register, columns past 4096 ignored
               sw = 8191; sh = 1; ow = 4096; oh = 1; n = 120;
            end
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  sw = $urandom_range(1, 64);
                  sh = $urandom_range(1, 64);
                  ow = $urandom_range(1, 4);
                  oh = $urandom_range(1, 4);
                  case ($urandom_range(0, 4))
                     0: ow = 0;
                     1: oh = 0;
                     2: sw = $urandom_range(17 * ow, 8191);
                     3: begin
                        ow = $urandom_range(4097, 8191);
                        sw = 8191;
                     end
                     default: sh = $urandom_range(17 * oh, 8191);
                  endcase
                  n = $urandom_range(20, 40);
               end else begin
                  kw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                    : $urandom_range(1, 3);
                  kh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                    : $urandom_range(1, 3);
                  ow = $urandom_range(1, 6);
                  oh = $urandom_range(1, 4);
                  sw = ow * kw + $urandom_range(0, ow - 1);
                  sh = oh * kh + $urandom_range(0, oh - 1);
                  n  = sw * sh * $urandom_range(1, 3);
                  if (n > 400) n = $urandom_range(200, 400);
               end
            end
         endcase
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         write_reg(REG_SRC_WIDTH, DIM_W'(sw));
         write_reg(REG_SRC_HEIGHT, DIM_W'(sh));
         write_reg(REG_OUT_WIDTH, DIM_W'(ow));
         write_reg(REG_OUT_HEIGHT, DIM_W'(oh));
         if ($urandom_range(0, 4) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(4, 7)), DIM_W'($urandom_range(0, 8191)));
         end
         for (int i = 0; i < n; i++) begin
            // hold the source until the output side has caught up
            if (i == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain_pixels();
            send_pixel(random_pixel(), 1'b0, '0);
         end
         sent += n;
         phase++;
      end

      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[box_average_image_downscaler_core] OK");
      end else begin
         $display("[box_average_image_downscaler_core] ERROR");
      end
      $finish;
   end

endmodule
